>>> sv/pbnc_pkg.sv
package pbnc_pkg;

	localparam int COMP_W = 6;
	localparam int COLOR_W = 3 * COMP_W;
	localparam int INDEX_W = 8;
	localparam int WEIGHT_W = 10;
	localparam int RATIO_W = 9;
	localparam int LEVEL_W = 8;
	localparam int DIST_W = 24;
	localparam int TERM_W = 22;
	localparam int RECIP_FRAC_BITS = 16;
	localparam int RECIP_W = RECIP_FRAC_BITS + 1;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [WEIGHT_W-1:0] RED_WEIGHT_RST = 10'd30;
	localparam logic [WEIGHT_W-1:0] GREEN_WEIGHT_RST = 10'd59;
	localparam logic [WEIGHT_W-1:0] BLUE_WEIGHT_RST = 10'd11;
	localparam logic [RATIO_W-1:0] BLEND_RATIO_RST = 9'd128;
	localparam logic [RATIO_W-1:0] SHADE_COUNT_RST = 9'd32;

	localparam logic signed [16:0] BLEND_ROUND = 17'sd128;
	localparam logic [23:0] SHADE_ROUND = 24'd32768;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_BLEND  = 2'd1,
		OP_SHADE  = 2'd2,
		OP_DIRECT = 2'd3
	} pbnc_op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RED_WEIGHT   = 3'd0,
		REG_GREEN_WEIGHT = 3'd1,
		REG_BLUE_WEIGHT  = 3'd2,
		REG_BLEND_RATIO  = 3'd3,
		REG_SHADE_COUNT  = 3'd4
	} pbnc_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ_A,
		S_READ_B,
		S_BLEND,
		S_DIVIDE,
		S_SHADE,
		S_SCAN,
		S_DRAIN
	} pbnc_state_t;

	typedef struct packed {
		logic                valid;
		logic                last;
		logic [INDEX_W-1:0]  index;
		logic [COLOR_W-1:0]  color;
		logic [DIST_W-1:0]   dist_sum;
	} pbnc_pkt_t;

	function automatic logic [COMP_W-1:0] blend_comp(
		input logic [COMP_W-1:0] a,
		input logic [COMP_W-1:0] b,
		input logic [RATIO_W-1:0] ratio
	);
		logic signed [6:0] d;
		logic signed [16:0] p;
		logic signed [16:0] q;
		logic signed [9:0] r;
		logic [COMP_W-1:0] res;
		d = $signed({1'b0, b}) - $signed({1'b0, a});
		p = 17'(d) * 17'($signed({1'b0, ratio})) + BLEND_ROUND;
		q = p >>> 8;
		r = 10'($signed({1'b0, a})) + 10'(q);
		if (r < 0) begin
			res = '0;
		end else if (r > 10'sd63) begin
			res = '1;
		end else begin
			res = r[COMP_W-1:0];
		end
		return res;
	endfunction

	function automatic logic [COMP_W-1:0] shade_comp(
		input logic [COMP_W-1:0] c,
		input logic [RECIP_W-1:0] t
	);
		logic [22:0] prod;
		logic [23:0] sum;
		prod = 23'(c) * 23'(t);
		sum = 24'(prod) + SHADE_ROUND;
		return sum[21:16];
	endfunction

endpackage

>>> sv/palette_blend_nearest_color.sv
// Nearest palette color search with blend and shade targets.
// Items enter on start while busy is low. A write (operation 0) stores one
// palette entry in that cycle and leaves busy low, so a new item may follow
// at once. A query (blend, shade or direct) raises busy until its search
// finishes, then nearest_index is shown for one cycle with done high.
// Configuration registers are written through cfg_write / cfg_index /
// cfg_data, one register per cycle. The user must write them only while no
// query is in flight; the block itself does not enforce this.
// A direct query goes straight to the scan; a blend query first reads both
// palette entries and blends them; a shade query reads them, runs the
// reciprocal divider and scales the first entry before the scan.
// The scan reads one palette entry per cycle from a dual-port RAM and
// feeds a row of three distance cells (red, green, blue), each adding its
// weighted squared difference in two stages; this read port sets the rate.
// Ties resolve to the highest index. done is a single-cycle strobe: the
// receiver cannot stall it. Reset restores the register defaults and idles
// the block; palette contents stay undefined until written.
module palette_blend_nearest_color #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] operation,
	input  logic [7:0] first_index,
	input  logic [7:0] second_index,
	input  logic [7:0] shade_level,
	input  logic [5:0] red_value,
	input  logic [5:0] green_value,
	input  logic [5:0] blue_value,
	input  logic       cfg_write,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data,
	output logic       done,
	output logic [7:0] nearest_index
);
	import pbnc_pkg::*;

	localparam int AW = $clog2(PALETTE_ENTRIES);

	pbnc_state_t state_q, state_d;

	logic [WEIGHT_W-1:0] red_weight_q, green_weight_q, blue_weight_q;
	logic [RATIO_W-1:0]  blend_ratio_q, shade_count_q;

	logic [1:0]         op_q;
	logic [INDEX_W-1:0] idx1_q, idx2_q;
	logic [LEVEL_W-1:0] lvl_q;
	logic [COLOR_W-1:0] e1_q;
	logic [AW-1:0]      scan_q;
	logic               head_valid_q, head_last_q;
	logic [INDEX_W-1:0] head_idx_q;
	logic [DIST_W-1:0]  best_dist_q;
	logic [INDEX_W-1:0] best_idx_q;
	logic               done_q;
	logic [INDEX_W-1:0] nearest_q;

	logic               accept;
	logic               ram_we;
	logic [AW-1:0]      raddr;
	logic [COLOR_W-1:0] rdata;
	logic               ok1, ok2;
	logic [COLOR_W-1:0] e2;
	logic               scan_last;
	logic [RATIO_W-1:0] cnt_eff;
	logic               shade_zero;
	logic               recip_load, recip_done;
	logic [RECIP_W-1:0] recip_t;
	logic               tgt_load;
	logic [2:0][5:0]    tgt_value;
	logic [2:0][9:0]    weights;
	logic               take;

	pbnc_pkt_t chain [4];

	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign ram_we = accept && (operation == OP_WRITE)
		&& (9'(first_index) < 9'(PALETTE_ENTRIES));
	assign ok1 = 9'(idx1_q) < 9'(PALETTE_ENTRIES);
	assign ok2 = 9'(idx2_q) < 9'(PALETTE_ENTRIES);
	assign e2 = ok2 ? rdata : '0;
	assign scan_last = (scan_q == AW'(PALETTE_ENTRIES - 1));
	assign cnt_eff = (shade_count_q == '0) ? 9'd1 : shade_count_q;
	assign shade_zero = {1'b0, lvl_q} >= cnt_eff;

	pbnc_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(PALETTE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(first_index[AW-1:0]),
		.wdata({red_value, green_value, blue_value}),
		.raddr(raddr),
		.rdata(rdata)
	);

	pbnc_recip u_recip (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (recip_load),
		.count (cnt_eff),
		.level (lvl_q),
		.ratio (recip_t),
		.done  (recip_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_weight_q <= RED_WEIGHT_RST;
			green_weight_q <= GREEN_WEIGHT_RST;
			blue_weight_q <= BLUE_WEIGHT_RST;
			blend_ratio_q <= BLEND_RATIO_RST;
			shade_count_q <= SHADE_COUNT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_RED_WEIGHT:   red_weight_q <= cfg_data;
				REG_GREEN_WEIGHT: green_weight_q <= cfg_data;
				REG_BLUE_WEIGHT:  blue_weight_q <= cfg_data;
				REG_BLEND_RATIO:  blend_ratio_q <= cfg_data[RATIO_W-1:0];
				REG_SHADE_COUNT:  shade_count_q <= cfg_data[RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		raddr = '0;
		recip_load = 1'b0;
		tgt_load = 1'b0;
		tgt_value = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (operation)
						OP_WRITE: state_d = S_IDLE;
						OP_BLEND, OP_SHADE: state_d = S_READ_A;
						OP_DIRECT: begin
							tgt_load = 1'b1;
							tgt_value[0] = red_value;
							tgt_value[1] = green_value;
							tgt_value[2] = blue_value;
							state_d = S_SCAN;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_READ_A: begin
				raddr = idx1_q[AW-1:0];
				state_d = S_READ_B;
			end
			S_READ_B: begin
				raddr = idx2_q[AW-1:0];
				if (op_q == OP_SHADE) begin
					recip_load = 1'b1;
					state_d = S_DIVIDE;
				end else begin
					state_d = S_BLEND;
				end
			end
			S_BLEND: begin
				tgt_load = 1'b1;
				tgt_value[0] = blend_comp(e1_q[17:12], e2[17:12], blend_ratio_q);
				tgt_value[1] = blend_comp(e1_q[11:6], e2[11:6], blend_ratio_q);
				tgt_value[2] = blend_comp(e1_q[5:0], e2[5:0], blend_ratio_q);
				state_d = S_SCAN;
			end
			S_DIVIDE: begin
				if (recip_done) begin
					state_d = S_SHADE;
				end
			end
			S_SHADE: begin
				tgt_load = 1'b1;
				if (!shade_zero) begin
					tgt_value[0] = shade_comp(e1_q[17:12], recip_t);
					tgt_value[1] = shade_comp(e1_q[11:6], recip_t);
					tgt_value[2] = shade_comp(e1_q[5:0], recip_t);
				end
				state_d = S_SCAN;
			end
			S_SCAN: begin
				raddr = scan_q;
				if (scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (chain[3].valid && chain[3].last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= operation;
			idx1_q <= first_index;
			idx2_q <= second_index;
			lvl_q <= shade_level;
		end
		if (state_q == S_READ_B) begin
			e1_q <= ok1 ? rdata : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			head_valid_q <= 1'b0;
			head_last_q <= 1'b0;
			head_idx_q <= '0;
		end else begin
			scan_q <= (state_q == S_SCAN) ? scan_q + AW'(1) : '0;
			head_valid_q <= (state_q == S_SCAN);
			head_last_q <= (state_q == S_SCAN) && scan_last;
			head_idx_q <= INDEX_W'(scan_q);
		end
	end

	assign weights[0] = red_weight_q;
	assign weights[1] = green_weight_q;
	assign weights[2] = blue_weight_q;

	always_comb begin
		chain[0].valid = head_valid_q;
		chain[0].last = head_last_q;
		chain[0].index = head_idx_q;
		chain[0].color = rdata;
		chain[0].dist_sum = '0;
	end

	for (genvar k = 0; k < 3; k++) begin : g_cell
		pbnc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (tgt_load),
			.target_in(tgt_value[k]),
			.weight   (weights[k]),
			.comp     (chain[k].color[COMP_W*(2-k) +: COMP_W]),
			.pkt_in   (chain[k]),
			.pkt_out  (chain[k+1])
		);
	end

	assign take = chain[3].valid
		&& ((chain[3].index == '0) || (chain[3].dist_sum <= best_dist_q));

	always_ff @(posedge clk) begin
		if (take) begin
			best_dist_q <= chain[3].dist_sum;
			best_idx_q <= chain[3].index;
		end
		if (chain[3].valid && chain[3].last) begin
			nearest_q <= take ? chain[3].index : best_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain[3].valid && chain[3].last;
		end
	end

	assign done = done_q;
	assign nearest_index = nearest_q;

endmodule

>>> sv/pbnc_ram.sv
module pbnc_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/pbnc_cell.sv
module pbnc_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [5:0]          target_in,
	input  logic [9:0]          weight,
	input  logic [5:0]          comp,
	input  pbnc_pkg::pbnc_pkt_t pkt_in,
	output pbnc_pkg::pbnc_pkt_t pkt_out
);
	import pbnc_pkg::*;

	logic [COMP_W-1:0] target_q;
	logic [COMP_W-1:0] diff;
	logic [11:0]       sq;
	logic [TERM_W-1:0] term;
	pbnc_pkt_t         pkt_s1;
	pbnc_pkt_t         pkt_s2;
	pbnc_pkt_t         pkt_sum;
	logic [11:0]       sq_s1;

	always_comb begin
		diff = (target_q > comp) ? target_q - comp : comp - target_q;
		sq = diff * diff;
		term = weight * sq_s1;
		pkt_sum = pkt_s1;
		pkt_sum.dist_sum = pkt_s1.dist_sum + DIST_W'(term);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			target_q <= target_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_s1 <= '0;
			sq_s1 <= '0;
			pkt_s2 <= '0;
		end else begin
			pkt_s1 <= pkt_in;
			sq_s1 <= sq;
			pkt_s2 <= pkt_sum;
		end
	end

	assign pkt_out = pkt_s2;

endmodule

>>> sv/pbnc_recip.sv
module pbnc_recip (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [8:0]  count,
	input  logic [7:0]  level,
	output logic [16:0] ratio,
	output logic        done
);
	import pbnc_pkg::*;

	logic [8:0]                 rem_q;
	logic [RECIP_FRAC_BITS-1:0] frac_q;
	logic                       int_q;
	logic [3:0]                 step_q;
	logic                       run_q;
	logic                       done_q;
	logic [9:0]                 rem2;
	logic                       ge;
	logic [8:0]                 rem_next;

	always_comb begin
		rem2 = {rem_q, 1'b0};
		ge = rem2 >= {1'b0, count};
		rem_next = ge ? 9'(rem2 - {1'b0, count}) : rem2[8:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == 4'(RECIP_FRAC_BITS - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			int_q <= (level == '0);
			rem_q <= (level == '0) ? 9'd0 : 9'(count - {1'b0, level});
			frac_q <= '0;
		end else if (run_q) begin
			rem_q <= rem_next;
			frac_q <= {frac_q[RECIP_FRAC_BITS-2:0], ge};
		end
	end

	assign ratio = {int_q, frac_q};
	assign done = done_q;

endmodule

>>> tb/tb_top.sv
module tb_top;
	import pbnc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAL_N = 256;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 300;

	typedef struct {
		pbnc_op_t    op;
		logic [7:0]  first;
		logic [7:0]  second;
		logic [7:0]  level;
		logic [5:0]  r;
		logic [5:0]  g;
		logic [5:0]  b;
	} palette_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [1:0] operation = OP_WRITE;
	logic [7:0] first_index = '0;
	logic [7:0] second_index = '0;
	logic [7:0] shade_level = '0;
	logic [5:0] red_value = '0;
	logic [5:0] green_value = '0;
	logic [5:0] blue_value = '0;
	logic       cfg_write = 1'b0;
	logic [2:0] cfg_index = REG_RED_WEIGHT;
	logic [9:0] cfg_data = '0;
	logic       done;
	logic [7:0] nearest_index;

	palette_blend_nearest_color #(
		.PALETTE_ENTRIES(PAL_N)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.first_index(first_index),
		.second_index(second_index),
		.shade_level(shade_level),
		.red_value(red_value),
		.green_value(green_value),
		.blue_value(blue_value),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.nearest_index(nearest_index)
	);

	always #6 clk = ~clk;

	logic [17:0] palette_model [PAL_N];
	logic [9:0]  w_red = RED_WEIGHT_RST;
	logic [9:0]  w_green = GREEN_WEIGHT_RST;
	logic [9:0]  w_blue = BLUE_WEIGHT_RST;
	logic [8:0]  mix_ratio = BLEND_RATIO_RST;
	logic [8:0]  shade_steps = SHADE_COUNT_RST;

	palette_item_t pending_items_q [$];
	logic [7:0]    expected_nearest_q [$];
	int            queries_sent = 0;
	int            results_seen = 0;
	int            error_count = 0;
	int            idle_pct = 0;
	bit            drain_mode = 1'b0;
	int            quiet_cycles = 0;

	function automatic int unsigned sq_diff(logic [5:0] a, logic [5:0] b);
		int d;
		d = int'(a) - int'(b);
		return int'(d * d);
	endfunction

	function automatic logic [7:0] search_nearest(logic [5:0] r, logic [5:0] g, logic [5:0] b);
		int unsigned best_dist;
		int unsigned cand_dist;
		logic [7:0]  best_idx;
		best_dist = 32'hFFFF_FFFF;
		best_idx = '0;
		for (int i = 0; i < PAL_N; i++) begin
			cand_dist = int'(w_red) * sq_diff(r, palette_model[i][17:12])
				+ int'(w_green) * sq_diff(g, palette_model[i][11:6])
				+ int'(w_blue) * sq_diff(b, palette_model[i][5:0]);
			if (cand_dist <= best_dist) begin
				best_dist = cand_dist;
				best_idx = 8'(i);
			end
		end
		return best_idx;
	endfunction

	function automatic logic [5:0] blend_channel(logic [5:0] a, logic [5:0] b);
		int p;
		int q;
		int r;
		p = (int'(b) - int'(a)) * int'(mix_ratio) + 128;
		q = p >>> 8;
		r = int'(a) + q;
		if (r < 0) begin
			r = 0;
		end else if (r > 63) begin
			r = 63;
		end
		return 6'(r);
	endfunction

	function automatic logic [5:0] shade_channel(logic [5:0] c, int unsigned scale);
		return 6'((int'(c) * scale + 32768) >> 16);
	endfunction

	task automatic accept_transaction();
		logic [17:0] e1;
		logic [17:0] e2;
		int unsigned cnt;
		int unsigned scale;
		logic [5:0]  tr;
		logic [5:0]  tg;
		logic [5:0]  tb;
		e1 = palette_model[first_index];
		e2 = palette_model[second_index];
		tr = red_value;
		tg = green_value;
		tb = blue_value;
		if (operation == OP_WRITE) begin
			palette_model[first_index] = {red_value, green_value, blue_value};
			return;
		end
		if (operation == OP_BLEND) begin
			tr = blend_channel(e1[17:12], e2[17:12]);
			tg = blend_channel(e1[11:6], e2[11:6]);
			tb = blend_channel(e1[5:0], e2[5:0]);
		end else if (operation == OP_SHADE) begin
			cnt = (shade_steps == 0) ? 1 : int'(shade_steps);
			if (int'(shade_level) >= cnt) begin
				tr = '0;
				tg = '0;
				tb = '0;
			end else begin
				scale = ((cnt - int'(shade_level)) << 16) / cnt;
				tr = shade_channel(e1[17:12], scale);
				tg = shade_channel(e1[11:6], scale);
				tb = shade_channel(e1[5:0], scale);
			end
		end
		expected_nearest_q.push_back(search_nearest(tr, tg, tb));
		queries_sent++;
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		palette_item_t item;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				accept_transaction();
			end
			if (!start || !busy) begin
				if (pending_items_q.size() != 0 && $urandom_range(99) >= idle_pct
						&& (!drain_mode || results_seen >= queries_sent)) begin
					item = pending_items_q.pop_front();
					operation <= item.op;
					first_index <= item.first;
					second_index <= item.second;
					shade_level <= item.level;
					red_value <= item.r;
					green_value <= item.g;
					blue_value <= item.b;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		logic [7:0] want;
		if (arst_n && done) begin
			if (expected_nearest_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual nearest_index %0d",
					$time, nearest_index);
				error_count++;
			end else begin
				want = expected_nearest_q.pop_front();
				if (nearest_index !== want) begin
					$display("%0t: nearest_index mismatch, expected %0d, actual %0d",
						$time, want, nearest_index);
					error_count++;
				end
			end
			results_seen <= results_seen + 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic push_item(pbnc_op_t op, int first, int second, int level,
			int r, int g, int b);
		palette_item_t item;
		item.op = op;
		item.first = 8'(first);
		item.second = 8'(second);
		item.level = 8'(level);
		item.r = 6'(r);
		item.g = 6'(g);
		item.b = 6'(b);
		pending_items_q.push_back(item);
	endtask

	function automatic palette_item_t random_item();
		palette_item_t item;
		int pick;
		int c;
		pick = $urandom_range(99);
		if (pick < 25) begin
			item.op = OP_WRITE;
		end else begin
			item.op = pbnc_op_t'($urandom_range(OP_BLEND, OP_DIRECT));
		end
		item.first = 8'($urandom);
		item.second = 8'($urandom);
		if ($urandom_range(1)) begin
			item.level = 8'($urandom_range(0, (shade_steps > 255) ? 255 : int'(shade_steps)));
		end else begin
			item.level = 8'($urandom);
		end
		item.r = 6'($urandom);
		item.g = 6'($urandom);
		item.b = 6'($urandom);
		if ($urandom_range(9) == 0) begin
			c = $urandom_range(1) ? 63 : 0;
			item.r = 6'(c);
			item.g = 6'(c);
			item.b = 6'(c);
		end else if (item.op == OP_WRITE && $urandom_range(4) == 0) begin
			{item.r, item.g, item.b} = palette_model[8'($urandom)];
		end
		return item;
	endfunction

	task automatic write_reg(pbnc_reg_t idx, logic [9:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_RED_WEIGHT:   w_red = value;
			REG_GREEN_WEIGHT: w_green = value;
			REG_BLUE_WEIGHT:  w_blue = value;
			REG_BLEND_RATIO:  mix_ratio = value[8:0];
			REG_SHADE_COUNT:  shade_steps = value[8:0];
			default: ;
		endcase
	endtask

	task automatic end_reg_writes();
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [9:0] random_weight();
		case ($urandom_range(4))
			0: return 10'd0;
			1: return 10'd1023;
			default: return 10'($urandom);
		endcase
	endfunction

	task automatic randomize_regs();
		write_reg(REG_RED_WEIGHT, random_weight());
		write_reg(REG_GREEN_WEIGHT, random_weight());
		write_reg(REG_BLUE_WEIGHT, random_weight());
		write_reg(REG_BLEND_RATIO, ($urandom_range(9) < 7) ? 10'($urandom_range(0, 256))
			: 10'($urandom));
		write_reg(REG_SHADE_COUNT, ($urandom_range(9) < 7) ? 10'($urandom_range(1, 64))
			: 10'($urandom));
		end_reg_writes();
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_items_q.size() != 0 || start || results_seen < queries_sent) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill every entry before any query; duplicates exercise tie to highest
		for (int i = 0; i < PAL_N; i++) begin
			push_item(OP_WRITE, i, $urandom, $urandom, $urandom, $urandom, $urandom);
		end
		pending_items_q[0].r = 0; pending_items_q[0].g = 0; pending_items_q[0].b = 0;
		pending_items_q[1].r = 63; pending_items_q[1].g = 63; pending_items_q[1].b = 63;
		pending_items_q[254].r = 0; pending_items_q[254].g = 0; pending_items_q[254].b = 0;
		pending_items_q[255].r = 63; pending_items_q[255].g = 63; pending_items_q[255].b = 63;
		push_item(OP_DIRECT, 0, 0, 0, 0, 0, 0);
		push_item(OP_DIRECT, 255, 255, 255, 63, 63, 63);
		push_item(OP_BLEND, 0, 255, 0, 0, 0, 0);
		push_item(OP_BLEND, 255, 0, 0, 0, 0, 0);
		push_item(OP_SHADE, 255, 0, 0, 0, 0, 0);
		push_item(OP_SHADE, 255, 0, 31, 0, 0, 0);
		push_item(OP_SHADE, 255, 0, 32, 0, 0, 0);
		push_item(OP_SHADE, 255, 0, 255, 0, 0, 0);
		push_item(OP_WRITE, 100, 0, 0, 21, 42, 7);
		push_item(OP_BLEND, 100, 100, 0, 0, 0, 0);
		push_item(OP_DIRECT, 0, 0, 0, 21, 42, 8);
		wait_idle();

		write_reg(REG_RED_WEIGHT, 10'd1023);
		write_reg(REG_GREEN_WEIGHT, 10'd0);
		write_reg(REG_BLUE_WEIGHT, 10'd0);
		write_reg(REG_BLEND_RATIO, 10'd0);
		write_reg(REG_SHADE_COUNT, 10'd1);
		end_reg_writes();
		@(negedge clk);
		push_item(OP_BLEND, 255, 0, 0, 0, 0, 0);
		push_item(OP_SHADE, 1, 0, 0, 0, 0, 0);
		push_item(OP_SHADE, 1, 0, 1, 0, 0, 0);
		push_item(OP_DIRECT, 0, 0, 0, 40, 3, 60);
		wait_idle();

		write_reg(REG_RED_WEIGHT, 10'd30);
		write_reg(REG_GREEN_WEIGHT, 10'd59);
		write_reg(REG_BLUE_WEIGHT, 10'd11);
		write_reg(REG_BLEND_RATIO, 10'd256);
		write_reg(REG_SHADE_COUNT, 10'd256);
		end_reg_writes();
		@(negedge clk);
		push_item(OP_BLEND, 0, 255, 0, 0, 0, 0);
		push_item(OP_SHADE, 255, 0, 255, 0, 0, 0);
		push_item(OP_SHADE, 100, 0, 128, 0, 0, 0);
		wait_idle();

		// ratio past 256 overshoots and the blend clamps to 0..63, zero shade count acts as one
		write_reg(REG_BLEND_RATIO, 10'h3FF);
		write_reg(REG_SHADE_COUNT, 10'd0);
		end_reg_writes();
		@(negedge clk);
		push_item(OP_BLEND, 0, 255, 0, 0, 0, 0);
		push_item(OP_BLEND, 255, 0, 0, 0, 0, 0);
		push_item(OP_SHADE, 100, 0, 0, 0, 0, 0);
		push_item(OP_SHADE, 100, 0, 1, 0, 0, 0);
		wait_idle();

		write_reg(REG_RED_WEIGHT, 10'd0);
		write_reg(REG_GREEN_WEIGHT, 10'd0);
		write_reg(REG_BLUE_WEIGHT, 10'd0);
		end_reg_writes();
		@(negedge clk);
		push_item(OP_DIRECT, 0, 0, 0, 17, 33, 5);
		push_item(OP_BLEND, 3, 9, 0, 0, 0, 0);
		wait_idle();

		write_reg(REG_RED_WEIGHT, 10'd1023);
		write_reg(REG_GREEN_WEIGHT, 10'd1023);
		write_reg(REG_BLUE_WEIGHT, 10'd1023);
		write_reg(REG_BLEND_RATIO, 10'd1);
		end_reg_writes();
		@(negedge clk);
		push_item(OP_DIRECT, 0, 0, 0, 63, 0, 63);
		push_item(OP_BLEND, 1, 254, 0, 0, 0, 0);
		wait_idle();

		for (int phase = 0; phase < 4; phase++) begin
			randomize_regs();
			@(negedge clk);
			case (phase)
				0: begin idle_pct = 0;  drain_mode = 1'b0; end
				1: begin idle_pct = 54; drain_mode = 1'b0; end
				2: begin idle_pct = 0;  drain_mode = 1'b1; end
				default: begin idle_pct = 25; drain_mode = 1'b0; end
			endcase
			for (int n = 0; n < 55; n++) begin
				pending_items_q.push_back(random_item());
			end
			wait_idle();
		end

		if (expected_nearest_q.size() != 0) begin
			$display("%0t: results missing, expected %0d more, actual 0",
				$time, expected_nearest_q.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/pbnc_pkg.sv
sv/pbnc_ram.sv
sv/pbnc_cell.sv
sv/pbnc_recip.sv
sv/palette_blend_nearest_color.sv
tb/tb_top.sv
